[hdl/rc_frame_decoder_assert.svh]
// assertion macros used by the checker file
`ifndef RC_FRAME_DECODER_ASSERT_SVH
`define RC_FRAME_DECODER_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define RCFD_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled while in reset
`define RCFD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[hdl/rcfd_pkg.sv]
// shared types, codes and functions of the rc frame decoder
package rcfd_pkg;

  typedef struct packed {
    logic [7:0]  rx_byte;
    logic [31:0] now_us;
  } in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [4:0]  chan_idx;
    logic [11:0] chan_value;
    logic [4:0]  chan_total;
    logic [6:0]  rssi_percent;
    logic [7:0]  lost_frames;
    logic        kill_latched;
    logic        last;
  } out_t;

  // request from the parser to the channel decoder
  typedef struct packed {
    logic        start;
    logic        cap24;
    logic [31:0] now_us;
  } dec_req_t;

  typedef enum logic [2:0] {
    PS_HUNT,
    PS_SYNC1,
    PS_SYNC2,
    PS_TYPE,
    PS_PAYLOAD,
    PS_CRC
  } ps_t;

  typedef enum logic [2:0] {
    DS_IDLE,
    DS_READ,
    DS_DRAIN,
    DS_HOTKEY,
    DS_EMIT
  } ds_t;

  localparam logic [2:0] ST_PROGRESS = 3'd0;
  localparam logic [2:0] ST_CHAN     = 3'd1;
  localparam logic [2:0] ST_DROP     = 3'd2;
  localparam logic [2:0] ST_CRCERR   = 3'd3;
  localparam logic [2:0] ST_UNKNOWN  = 3'd4;
  localparam logic [2:0] ST_IGNORED  = 3'd5;

  localparam logic [2:0] CFG_SYNC_FIRST     = 3'd0;
  localparam logic [2:0] CFG_SYNC_SECOND    = 3'd1;
  localparam logic [2:0] CFG_TYPE_TWELVE    = 3'd2;
  localparam logic [2:0] CFG_TYPE_TWENTYFOR = 3'd3;
  localparam logic [2:0] CFG_TYPE_POSITION  = 3'd4;
  localparam logic [2:0] CFG_CHANNEL_LIMIT  = 3'd5;

  localparam logic [7:0] CRC_POLY   = 8'h07;
  localparam logic [11:0] PWM_LOW   = 12'd1000;
  localparam logic [11:0] PWM_HIGH  = 12'd2000;
  localparam logic [7:0] LOST_BAD   = 8'd100;
  localparam logic [3:0] MAP_VER_OK = 4'hF;

  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

  // two-bit switch field to 1000/1500/2000/2500
  function automatic logic [11:0] vsw(input logic [1:0] f);
    logic [11:0] v;
    unique case (f)
      2'd0: v = 12'd1000;
      2'd1: v = 12'd1500;
      2'd2: v = 12'd2000;
      default: v = 12'd2500;
    endcase
    return v;
  endfunction

endpackage

[hdl/rcfd_store.sv]
// payload byte memory with per-entry valid bits, registered read
module rcfd_store #(
  parameter int MAX_PAYLOAD = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       wr_en,
  input  logic [7:0] wr_addr,
  input  logic [7:0] wr_data,
  input  logic [7:0] rd_addr,
  output logic [7:0] rd_data
);
  localparam int AW = $clog2(MAX_PAYLOAD);

  logic [7:0]             mem [MAX_PAYLOAD];
  logic [MAX_PAYLOAD-1:0] vld_r;
  logic [7:0]             mem_q_r;
  logic                   sel_r;
  logic                   rd_in;
  logic                   wr_in;

  assign rd_in = rd_addr < 8'(MAX_PAYLOAD);
  assign wr_in = wr_addr < 8'(MAX_PAYLOAD);

  always_ff @(posedge clk) begin
    if (wr_en && wr_in) begin
      mem[wr_addr[AW-1:0]] <= wr_data;
    end
    mem_q_r <= mem[rd_addr[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      sel_r <= 1'b0;
    end else begin
      if (wr_en && wr_in) begin
        vld_r[wr_addr[AW-1:0]] <= 1'b1;
      end
      sel_r <= rd_in && vld_r[rd_addr[AW-1:0]];
    end
  end

  // never-written entries and addresses past the store read as zero
  assign rd_data = sel_r ? mem_q_r : 8'd0;
endmodule

[hdl/rcfd_decode.sv]
// channel decoder: reads payload bytes, builds channels, hotkey, emits the run
module rcfd_decode #(
  parameter int HOTKEY_WINDOW_US     = 1000000,
  parameter int CHANNEL_BYTES_OFFSET = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  rcfd_pkg::dec_req_t req,
  input  logic [4:0]        channel_limit,
  output logic              busy,
  output logic              kill,
  output logic [7:0]        rd_addr,
  input  logic [7:0]        rd_data,
  output logic              emit_valid,
  output rcfd_pkg::out_t    emit_data,
  input  logic              emit_take
);
  localparam logic [5:0] LAST_READ = 6'd37;

  rcfd_pkg::ds_t ds_r, ds_nxt;

  logic [5:0]  ri_r;
  logic        rv_r;
  logic [5:0]  rj_r;
  logic [1:0]  ph_r;
  logic [3:0]  pair_r;
  logic [7:0]  b0_r, b1_r;
  logic [7:0]  rssi_raw_r, lost_raw_r;
  logic [6:0]  rssi_r;
  logic [7:0]  lost_r;
  logic        cap24_r;
  logic [31:0] now_r;
  logic [11:0] ch_r [24];
  logic [4:0]  k_r;

  logic        arm_prev_r;
  logic [1:0]  press_r;
  logic [31:0] start_r;
  logic        kill_r;

  logic [4:0]  cap;
  logic [4:0]  count;
  logic [6:0]  stride;
  logic [5:0]  total6;
  logic [4:0]  total;
  logic [14:0] rx100;
  logic [14:0] rdiv;

  assign cap    = cap24_r ? 5'd24 : 5'd12;
  assign count  = (channel_limit < cap) ? channel_limit : cap;
  assign stride = 7'((8'(count) * 8'd3) >> 1);
  assign total6 = 6'(count) + 6'd2;
  assign total  = (total6 > 6'd24) ? 5'd24 : total6[4:0];
  // floor(x/255) for x up to 25500, the largest rssi byte times 100
  assign rx100  = 15'(rssi_raw_r) * 15'd100;
  assign rdiv   = (rx100 + 15'd1 + (rx100 >> 8)) >> 8;

  always_comb begin
    ds_nxt = ds_r;
    unique case (ds_r)
      rcfd_pkg::DS_IDLE:   if (req.start) ds_nxt = rcfd_pkg::DS_READ;
      rcfd_pkg::DS_READ:   if (ri_r == LAST_READ) ds_nxt = rcfd_pkg::DS_DRAIN;
      rcfd_pkg::DS_DRAIN:  ds_nxt = rcfd_pkg::DS_HOTKEY;
      rcfd_pkg::DS_HOTKEY: ds_nxt = rcfd_pkg::DS_EMIT;
      rcfd_pkg::DS_EMIT:   if (emit_take && emit_data.last) ds_nxt = rcfd_pkg::DS_IDLE;
      default:             ds_nxt = rcfd_pkg::DS_IDLE;
    endcase
  end

  always_comb begin
    unique case (ri_r)
      6'd0:    rd_addr = 8'd2;
      6'd1:    rd_addr = 8'd3;
      default: rd_addr = 8'(CHANNEL_BYTES_OFFSET) + 8'(ri_r) - 8'd2;
    endcase
    busy                   = ds_r != rcfd_pkg::DS_IDLE;
    emit_valid             = ds_r == rcfd_pkg::DS_EMIT;
    emit_data.status       = rcfd_pkg::ST_CHAN;
    emit_data.chan_idx     = k_r;
    emit_data.chan_value   = ch_r[k_r];
    emit_data.chan_total   = total;
    emit_data.rssi_percent = rssi_r;
    emit_data.lost_frames  = lost_r;
    emit_data.kill_latched = kill_r;
    emit_data.last         = (k_r + 5'd1) == total;
  end

  assign kill = kill_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ds_r       <= rcfd_pkg::DS_IDLE;
      rv_r       <= 1'b0;
      arm_prev_r <= 1'b0;
      press_r    <= 2'd0;
      start_r    <= '0;
      kill_r     <= 1'b0;
    end else begin
      ds_r <= ds_nxt;
      rv_r <= ds_r == rcfd_pkg::DS_READ;
      if (ds_r == rcfd_pkg::DS_HOTKEY) begin : hk
        logic first, in_win, complete, arm;
        first    = press_r == 2'd0;
        in_win   = (now_r - start_r) < 32'(HOTKEY_WINDOW_US);
        complete = press_r > 2'd2;
        arm      = ch_r[8][1];
        if (complete) kill_r <= 1'b1;
        if (ch_r[0] < rcfd_pkg::PWM_LOW && (first || in_win) && !complete) begin
          if (!arm_prev_r && arm) begin
            if (first) start_r <= now_r;
            press_r <= press_r + 2'd1;
          end
        end else begin
          press_r <= 2'd0;
          start_r <= '0;
        end
        arm_prev_r <= arm;
      end
    end
  end

  always_ff @(posedge clk) begin
    rj_r <= ri_r;
    unique case (ds_r)
      rcfd_pkg::DS_IDLE: begin
        ri_r    <= '0;
        ph_r    <= '0;
        pair_r  <= '0;
        k_r     <= '0;
        cap24_r <= req.cap24;
        now_r   <= req.now_us;
      end
      rcfd_pkg::DS_READ, rcfd_pkg::DS_DRAIN: begin
        if (ds_r == rcfd_pkg::DS_READ) ri_r <= ri_r + 6'd1;
        if (rv_r) begin
          if (rj_r == 6'd0) begin
            rssi_raw_r <= rd_data;
          end else if (rj_r == 6'd1) begin
            lost_raw_r <= rd_data;
          end else begin
            unique case (ph_r)
              2'd0: b0_r <= rd_data;
              2'd1: b1_r <= rd_data;
              default: begin
                if (8'(pair_r) * 8'd3 < 8'(stride)) begin
                  ch_r[{pair_r, 1'b0}] <= {b0_r, b1_r[7:4]};
                  ch_r[{pair_r, 1'b1}] <= {b1_r[3:0], rd_data};
                end else begin
                  ch_r[{pair_r, 1'b0}] <= '0;
                  ch_r[{pair_r, 1'b1}] <= '0;
                end
                pair_r <= pair_r + 4'd1;
              end
            endcase
            ph_r <= (ph_r == 2'd2) ? 2'd0 : ph_r + 2'd1;
          end
        end
      end
      rcfd_pkg::DS_HOTKEY: begin
        rssi_r <= rdiv[6:0];
        lost_r <= (ch_r[8][11:8] != rcfd_pkg::MAP_VER_OK) ? rcfd_pkg::LOST_BAD : lost_raw_r;
        ch_r[7]  <= ch_r[8][1] ? rcfd_pkg::PWM_HIGH : rcfd_pkg::PWM_LOW;
        ch_r[8]  <= ch_r[8][0] ? rcfd_pkg::PWM_HIGH : rcfd_pkg::PWM_LOW;
        ch_r[9]  <= rcfd_pkg::vsw(ch_r[7][1:0]);
        ch_r[10] <= rcfd_pkg::vsw(ch_r[7][3:2]);
        ch_r[11] <= rcfd_pkg::vsw(ch_r[7][5:4]);
        ch_r[12] <= rcfd_pkg::vsw(ch_r[7][7:6]);
        // kill channel shows the latch from before this frame
        ch_r[13] <= kill_r ? rcfd_pkg::PWM_HIGH : rcfd_pkg::PWM_LOW;
      end
      rcfd_pkg::DS_EMIT: begin
        if (emit_take) k_r <= k_r + 5'd1;
      end
      default: begin
      end
    endcase
  end
endmodule

[hdl/rc_frame_decoder.sv]
// top level: byte parser with crc, payload store, channel decoder, output register
// Decodes a framed rc receiver byte stream. Each byte enters on the in_ channel
// (in_valid/in_ready, payload in_data) with a microsecond timestamp. Every byte
// gives one status item on the out_ channel, except the crc byte of a good
// twelve- or twenty-four-channel frame, which gives a run of chan_total channel
// items instead, the final one flagged by last.
// A status item appears in the output register in the cycle after its byte is
// taken, so plain bytes run at one per cycle while out_ready stays high. A
// channel frame holds in_ready low while the decoder reads 38 payload bytes
// from the store (one read per cycle) and runs the hotkey logic, then while it
// emits its channel items, one per cycle while out_ready stays high. The user
// must write configuration through cfg_we/cfg_addr/cfg_wdata only while idle;
// the block does not enforce this. Reset returns the parser to sync hunting,
// clears the payload store valid bits (unwritten bytes read as zero), the
// hotkey and the kill latch. When the receiver stalls the output register
// holds its item and no new byte or channel item is taken until it drains.
module rc_frame_decoder #(
  parameter int MAX_PAYLOAD          = 64,
  parameter int HOTKEY_WINDOW_US     = 1000000,
  parameter int CHANNEL_BYTES_OFFSET = 4
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  rcfd_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output rcfd_pkg::out_t out_data,
  input  logic           cfg_we,
  input  logic [2:0]     cfg_addr,
  input  logic [7:0]     cfg_wdata
);
  localparam logic [8:0] LEN_MAX = 9'(MAX_PAYLOAD + 2);

  logic [7:0] sync_first_r, sync_second_r, type12_r, type24_r, typepos_r;
  logic [4:0] chan_limit_r;

  rcfd_pkg::ps_t ps_r, ps_nxt;
  logic [7:0] len_r, len_nxt;
  logic [7:0] type_r, type_nxt;
  logic [7:0] cnt_r, cnt_nxt;
  logic [7:0] crc_r, crc_nxt;

  logic              acc;
  logic              slot_free;
  logic [7:0]        b;
  logic [2:0]        st;
  logic              st_valid;
  logic              mem_we;
  rcfd_pkg::dec_req_t req;
  logic              dec_busy;
  logic              dec_kill;
  logic [7:0]        rd_addr, rd_data;
  logic              emit_valid, emit_take;
  rcfd_pkg::out_t    emit_data;
  rcfd_pkg::out_t    st_item;
  logic              out_valid_r;
  rcfd_pkg::out_t    out_r;

  assign b         = in_data.rx_byte;
  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = !dec_busy && slot_free;
  assign acc       = in_valid && in_ready;
  assign emit_take = emit_valid && slot_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_first_r  <= 8'h55;
      sync_second_r <= 8'h55;
      type12_r      <= 8'd0;
      type24_r      <= 8'd2;
      typepos_r     <= 8'd3;
      chan_limit_r  <= 5'd24;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        rcfd_pkg::CFG_SYNC_FIRST:     sync_first_r  <= cfg_wdata;
        rcfd_pkg::CFG_SYNC_SECOND:    sync_second_r <= cfg_wdata;
        rcfd_pkg::CFG_TYPE_TWELVE:    type12_r      <= cfg_wdata;
        rcfd_pkg::CFG_TYPE_TWENTYFOR: type24_r      <= cfg_wdata;
        rcfd_pkg::CFG_TYPE_POSITION:  typepos_r     <= cfg_wdata;
        rcfd_pkg::CFG_CHANNEL_LIMIT:  chan_limit_r  <= cfg_wdata[4:0];
        default: begin
        end
      endcase
    end
  end

  // parser next state
  always_comb begin
    ps_nxt = ps_r;
    if (acc) begin
      unique case (ps_r)
        rcfd_pkg::PS_HUNT:
          ps_nxt = (b == sync_first_r) ? rcfd_pkg::PS_SYNC1 : rcfd_pkg::PS_HUNT;
        rcfd_pkg::PS_SYNC1:
          ps_nxt = (b == sync_second_r) ? rcfd_pkg::PS_SYNC2 : rcfd_pkg::PS_HUNT;
        rcfd_pkg::PS_SYNC2:
          ps_nxt = (b >= 8'd2 && 9'(b) <= LEN_MAX) ? rcfd_pkg::PS_TYPE : rcfd_pkg::PS_HUNT;
        rcfd_pkg::PS_TYPE:
          ps_nxt = (len_r <= 8'd2) ? rcfd_pkg::PS_CRC : rcfd_pkg::PS_PAYLOAD;
        rcfd_pkg::PS_PAYLOAD:
          if (9'(cnt_r) + 9'd3 >= 9'(len_r)) ps_nxt = rcfd_pkg::PS_CRC;
        rcfd_pkg::PS_CRC:
          ps_nxt = rcfd_pkg::PS_HUNT;
        default:
          ps_nxt = rcfd_pkg::PS_HUNT;
      endcase
    end
  end

  // parser outputs and datapath
  always_comb begin
    len_nxt    = len_r;
    type_nxt   = type_r;
    cnt_nxt    = cnt_r;
    crc_nxt    = crc_r;
    st         = rcfd_pkg::ST_PROGRESS;
    st_valid   = acc;
    mem_we     = 1'b0;
    req.start  = 1'b0;
    req.cap24  = type_r != type12_r;
    req.now_us = in_data.now_us;
    if (acc) begin
      unique case (ps_r)
        rcfd_pkg::PS_HUNT: begin
          if (b != sync_first_r) st = rcfd_pkg::ST_DROP;
        end
        rcfd_pkg::PS_SYNC1: begin
        end
        rcfd_pkg::PS_SYNC2: begin
          if (b >= 8'd2 && 9'(b) <= LEN_MAX) begin
            len_nxt = b;
            cnt_nxt = '0;
            crc_nxt = rcfd_pkg::crc8_byte(8'd0, b);
          end
        end
        rcfd_pkg::PS_TYPE: begin
          type_nxt = b;
          cnt_nxt  = '0;
          crc_nxt  = rcfd_pkg::crc8_byte(crc_r, b);
        end
        rcfd_pkg::PS_PAYLOAD: begin
          if (9'(cnt_r) < 9'(MAX_PAYLOAD)) begin
            mem_we  = 1'b1;
            crc_nxt = rcfd_pkg::crc8_byte(crc_r, b);
          end
          cnt_nxt = cnt_r + 8'd1;
        end
        rcfd_pkg::PS_CRC: begin
          if (crc_r != b) begin
            st = rcfd_pkg::ST_CRCERR;
          end else if (type_r == type12_r || type_r == type24_r) begin
            st_valid  = 1'b0;
            req.start = 1'b1;
          end else if (type_r == typepos_r) begin
            st = rcfd_pkg::ST_IGNORED;
          end else begin
            st = rcfd_pkg::ST_UNKNOWN;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ps_r   <= rcfd_pkg::PS_HUNT;
      len_r  <= '0;
      type_r <= '0;
      cnt_r  <= '0;
      crc_r  <= '0;
    end else begin
      ps_r   <= ps_nxt;
      len_r  <= len_nxt;
      type_r <= type_nxt;
      cnt_r  <= cnt_nxt;
      crc_r  <= crc_nxt;
    end
  end

  rcfd_store #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_store (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (mem_we),
    .wr_addr(cnt_r),
    .wr_data(b),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  rcfd_decode #(
    .HOTKEY_WINDOW_US    (HOTKEY_WINDOW_US),
    .CHANNEL_BYTES_OFFSET(CHANNEL_BYTES_OFFSET)
  ) u_decode (
    .clk          (clk),
    .rst_n        (rst_n),
    .req          (req),
    .channel_limit(chan_limit_r),
    .busy         (dec_busy),
    .kill         (dec_kill),
    .rd_addr      (rd_addr),
    .rd_data      (rd_data),
    .emit_valid   (emit_valid),
    .emit_data    (emit_data),
    .emit_take    (emit_take)
  );

  // single status item for a byte that starts no channel run
  always_comb begin
    st_item              = '0;
    st_item.status       = st;
    st_item.kill_latched = dec_kill;
    st_item.last         = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (st_valid || emit_take) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_take) begin
      out_r <= emit_data;
    end else if (st_valid) begin
      out_r <= st_item;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;
endmodule

[hdl/rcfd_checker.sv]
// port-level checker for the rc frame decoder and its bind
`include "rc_frame_decoder_assert.svh"

module rcfd_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           out_valid,
  input logic           out_ready,
  input rcfd_pkg::out_t out_data
);
  `RCFD_ASSERT_IMPLIES(a_status_last, out_valid && out_data.status != rcfd_pkg::ST_CHAN, out_data.last && out_data.chan_total == 5'd0, "status item must be single and carry no channel run")
  `RCFD_ASSERT_IMPLIES(a_index_range, out_valid && out_data.status == rcfd_pkg::ST_CHAN, out_data.chan_idx < out_data.chan_total && out_data.rssi_percent <= 7'd100, "channel item fields out of range")
  `RCFD_ASSERT_NEXT(a_kill_sticky, out_valid && out_data.kill_latched, !out_valid || out_data.kill_latched, "kill latch dropped")
  `RCFD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "stalled output item changed")
endmodule

bind rc_frame_decoder rcfd_checker u_rcfd_checker (.*);
